>>> rtl/ffca_pkg.sv
// shared types and constants for the first-fit cell map allocator
`timescale 1ns / 1ps

package ffca_pkg;

    localparam int unsigned CELL_COUNT_DEF = 128;
    localparam int unsigned CELL_BYTES_DEF = 8;
    localparam int unsigned ADDR_W         = 16;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned CMP_W          = ADDR_W + 1;

    typedef enum logic [2:0] {
        MARK_FREE,
        MARK_START,
        MARK_MIDDLE,
        MARK_LAST,
        MARK_SINGLE
    } t_mark;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NOSPACE,
        ST_BADADDR,
        ST_CORRUPT
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_MARK,
        CMD_DIV,
        CMD_CHECK,
        CMD_WALK,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic mark_done;
        logic off_bad;
        logic chk_walk;
        logic walk_done;
    } t_dp_sts;

endpackage

>>> rtl/first_fit_cell_map_allocator_unit.sv
// first-fit cell map allocator: one request word in, one status word out
// allocate: first-fit scan one cell per cycle, then marking one cell per cycle
// free: cell index by reciprocal multiply, then walk one cell per cycle
// one request in flight, next taken in the cycle after the result registers, even while it waits
// synchronous active-low reset: all cells free at once, base address 0, no warm-up
`timescale 1ns / 1ps

module first_fit_cell_map_allocator_unit #(
    parameter int unsigned CELL_COUNT = ffca_pkg::CELL_COUNT_DEF,
    parameter int unsigned CELL_BYTES = ffca_pkg::CELL_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_size_bytes,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffca_pkg::STATUS_W-1:0] o_status,
    output logic [ffca_pkg::ADDR_W-1:0]   o_block_address
);

    ffca_pkg::t_cmd    cmd;
    ffca_pkg::t_dp_sts sts;

    ffca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffca_dp #(
        .CELL_COUNT (CELL_COUNT),
        .CELL_BYTES (CELL_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_size_bytes    (i_size_bytes),
        .i_free_address  (i_free_address),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_block_address (o_block_address)
    );

endmodule

>>> rtl/ffca_dp.sv
// datapath: cell map memory, scan and walk pointers, result and output registers
`timescale 1ns / 1ps

module ffca_dp #(
    parameter int unsigned CELL_COUNT = ffca_pkg::CELL_COUNT_DEF,
    parameter int unsigned CELL_BYTES = ffca_pkg::CELL_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_size_bytes,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_free_address,
    input  ffca_pkg::t_cmd                i_cmd,
    output ffca_pkg::t_dp_sts             o_sts,
    output logic [ffca_pkg::STATUS_W-1:0] o_status,
    output logic [ffca_pkg::ADDR_W-1:0]   o_block_address
);

    localparam int unsigned AW         = ffca_pkg::ADDR_W;
    localparam int unsigned CW         = ffca_pkg::CMP_W;
    localparam int unsigned IDX_W      = $clog2(CELL_COUNT);
    localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int unsigned HEAP_BYTES = CELL_COUNT * CELL_BYTES;
    localparam int unsigned RUN_W      = $clog2(HEAP_BYTES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_CELLS = CNT_W'(CELL_COUNT);

    // cell index as offset times a rounded-up reciprocal of the cell size
    localparam int unsigned       DIV_SH  = AW + $clog2(CELL_BYTES);
    localparam int unsigned       MUL_W   = AW + 1;
    localparam int unsigned       PROD_W  = AW + MUL_W;
    localparam longint unsigned   DIV_ONE = 64'd1 << DIV_SH;
    localparam longint unsigned   DIV_MUL = (DIV_ONE + CELL_BYTES - 1) / CELL_BYTES;
    localparam logic [MUL_W-1:0]  DIV_M   = MUL_W'(DIV_MUL);

    ffca_pkg::t_mark   r_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_vld;
    ffca_pkg::t_mark   r_rd_mem;
    logic              r_rd_vld;
    logic              r_rd_ok;

    logic [AW-1:0]     r_base;
    logic [AW-1:0]     r_size;
    logic [AW-1:0]     r_offset;
    logic [CNT_W-1:0]  r_ptr;
    logic [RUN_W-1:0]  r_run_bytes;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_last;
    logic [IDX_W-1:0]  r_idx;
    ffca_pkg::t_status r_res_status;
    logic [AW-1:0]     r_res_addr;
    ffca_pkg::t_status r_out_status;
    logic [AW-1:0]     r_out_addr;

    logic              rd_in_range;
    logic [IDX_W-1:0]  ptr_idx;
    logic [CNT_W-1:0]  chk_cnt;
    logic [IDX_W-1:0]  chk_idx;
    logic              off_bad;
    logic [PROD_W-1:0] div_prod;
    logic [IDX_W-1:0]  div_idx;
    logic [IDX_W-1:0]  rd_addr;
    ffca_pkg::t_mark   mark;
    ffca_pkg::t_mark   mark_val;
    logic [CW-1:0]     run_sum;
    logic [IDX_W-1:0]  first_now;
    logic [AW-1:0]     hit_addr;

    always_comb begin
        rd_in_range = r_ptr < CNT_CELLS;
        ptr_idx     = r_ptr[IDX_W-1:0];
        chk_cnt     = r_ptr - CNT_W'(1);
        chk_idx     = chk_cnt[IDX_W-1:0];
        off_bad     = CW'(r_offset) >= CW'(HEAP_BYTES);
        div_prod    = PROD_W'(r_offset) * PROD_W'(DIV_M);
        div_idx     = div_prod[DIV_SH +: IDX_W];
        rd_addr     = ((i_cmd == ffca_pkg::CMD_DIV) && !off_bad) ? div_idx :
                      (rd_in_range ? ptr_idx : '0);
        mark        = r_rd_vld ? r_rd_mem : ffca_pkg::MARK_FREE;
        run_sum     = CW'(r_run_bytes) + CW'(CELL_BYTES);
        first_now   = (r_run_bytes == '0) ? chk_idx : r_first;
        hit_addr    = r_base + AW'(first_now) * AW'(CELL_BYTES);

        if (r_first == r_last) begin
            mark_val = ffca_pkg::MARK_SINGLE;
        end else if (ptr_idx == r_first) begin
            mark_val = ffca_pkg::MARK_START;
        end else if (ptr_idx == r_last) begin
            mark_val = ffca_pkg::MARK_LAST;
        end else begin
            mark_val = ffca_pkg::MARK_MIDDLE;
        end

        o_sts.scan_hit  = r_rd_ok && (mark == ffca_pkg::MARK_FREE) &&
                          (run_sum >= CW'(r_size));
        o_sts.scan_end  = r_rd_ok && !o_sts.scan_hit && (chk_idx == LAST_IDX);
        o_sts.mark_done = ptr_idx == r_last;
        o_sts.off_bad   = off_bad;
        o_sts.chk_walk  = (mark == ffca_pkg::MARK_START) && (r_idx != LAST_IDX);
        o_sts.walk_done = r_rd_ok && ((mark != ffca_pkg::MARK_MIDDLE) ||
                                      (chk_idx == LAST_IDX));
    end

    // mark memory
    always_ff @(posedge i_clk) begin
        if (i_cmd == ffca_pkg::CMD_MARK) begin
            r_mem[ptr_idx] <= mark_val;
        end
        r_rd_mem <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            r_rd_vld <= r_vld[rd_addr];
            r_rd_ok  <= ((i_cmd == ffca_pkg::CMD_SCAN) || (i_cmd == ffca_pkg::CMD_WALK)) &&
                        rd_in_range;
            case (i_cmd)
                ffca_pkg::CMD_MARK: begin
                    r_vld[ptr_idx] <= 1'b1;
                end
                ffca_pkg::CMD_CHECK: begin
                    if ((mark == ffca_pkg::MARK_START) && (r_idx == LAST_IDX)) begin
                        r_vld <= '0;
                    end else if ((mark == ffca_pkg::MARK_SINGLE) ||
                                 (mark == ffca_pkg::MARK_START)) begin
                        r_vld[r_idx] <= 1'b0;
                    end
                end
                ffca_pkg::CMD_WALK: begin
                    if (r_rd_ok) begin
                        if ((mark == ffca_pkg::MARK_LAST) ||
                            ((mark == ffca_pkg::MARK_MIDDLE) && (chk_idx != LAST_IDX))) begin
                            r_vld[chk_idx] <= 1'b0;
                        end else begin
                            r_vld <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ffca_pkg::CMD_LOAD: begin
                r_size      <= i_size_bytes;
                r_offset    <= i_free_address - r_base;
                r_ptr       <= '0;
                r_run_bytes <= '0;
                r_idx       <= '0;
            end
            ffca_pkg::CMD_SCAN: begin
                if (rd_in_range) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                if (r_rd_ok) begin
                    if (o_sts.scan_hit) begin
                        r_first      <= first_now;
                        r_last       <= chk_idx;
                        r_ptr        <= CNT_W'(first_now);
                        r_res_status <= ffca_pkg::ST_OK;
                        r_res_addr   <= hit_addr;
                    end else if (mark == ffca_pkg::MARK_FREE) begin
                        if (r_run_bytes == '0) begin
                            r_first <= chk_idx;
                        end
                        r_run_bytes <= RUN_W'(run_sum);
                    end else begin
                        r_run_bytes <= '0;
                    end
                    if (o_sts.scan_end) begin
                        r_res_status <= ffca_pkg::ST_NOSPACE;
                        r_res_addr   <= '0;
                    end
                end
            end
            ffca_pkg::CMD_MARK: begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            ffca_pkg::CMD_DIV: begin
                if (off_bad) begin
                    r_res_status <= ffca_pkg::ST_BADADDR;
                    r_res_addr   <= '0;
                end else begin
                    r_idx <= div_idx;
                end
            end
            ffca_pkg::CMD_CHECK: begin
                r_ptr      <= CNT_W'(r_idx) + CNT_W'(1);
                r_res_addr <= '0;
                case (mark)
                    ffca_pkg::MARK_SINGLE: r_res_status <= ffca_pkg::ST_OK;
                    ffca_pkg::MARK_START: begin
                        r_res_status <= (r_idx == LAST_IDX) ? ffca_pkg::ST_CORRUPT :
                                                              ffca_pkg::ST_OK;
                    end
                    default: r_res_status <= ffca_pkg::ST_BADADDR;
                endcase
            end
            ffca_pkg::CMD_WALK: begin
                if (rd_in_range) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                if (r_rd_ok && o_sts.walk_done) begin
                    r_res_status <= (mark == ffca_pkg::MARK_LAST) ? ffca_pkg::ST_OK :
                                                                   ffca_pkg::ST_CORRUPT;
                end
            end
            ffca_pkg::CMD_OUT: begin
                r_out_status <= r_res_status;
                r_out_addr   <= r_res_addr;
            end
            default: begin
            end
        endcase
    end

    assign o_status        = r_out_status;
    assign o_block_address = r_out_addr;

endmodule

>>> rtl/ffca_ctrl.sv
// controller: request sequencing and input/output word handshakes
`timescale 1ns / 1ps

module ffca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  ffca_pkg::t_dp_sts i_sts,
    output ffca_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DIV,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        n_state     = r_state;
        o_cmd       = ffca_pkg::CMD_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = ffca_pkg::CMD_LOAD;
                    n_state = i_req_type ? S_DIV : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd = ffca_pkg::CMD_SCAN;
                if (i_sts.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd = ffca_pkg::CMD_MARK;
                if (i_sts.mark_done) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd   = ffca_pkg::CMD_DIV;
                n_state = i_sts.off_bad ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                o_cmd   = ffca_pkg::CMD_CHECK;
                n_state = i_sts.chk_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                o_cmd = ffca_pkg::CMD_WALK;
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd       = ffca_pkg::CMD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
